@@ hdl/att_pkg.sv @@
package att_pkg;

  // Fixed field widths
  localparam int TIME_W    = 40;
  localparam int FACTOR_W  = 24;
  localparam int DELAY_W   = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CHUNK_W   = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TRIGGER_FACTOR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE_FACTOR         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FACTOR         = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_CEILING    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FLOOR      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_DELAY           = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_DELAY           = 4'd7;

  // Register reset values that do not depend on the value width
  localparam logic [FACTOR_W-1:0] LOWER_TRIGGER_RST = 24'd32768;
  localparam logic [FACTOR_W-1:0] RAISE_FACTOR_RST  = 24'd98304;
  localparam logic [FACTOR_W-1:0] LOWER_FACTOR_RST  = 24'd49152;
  localparam logic [DELAY_W-1:0]  RISE_DELAY_RST    = 32'd60;
  localparam logic [DELAY_W-1:0]  FALL_DELAY_RST    = 32'd60;

  typedef enum logic [1:0] {
    MODE_OK      = 2'd0,
    MODE_RISING  = 2'd1,
    MODE_FALLING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_MUL,
    S_RND,
    S_APPLY,
    S_OUT
  } state_t;

  // What the current scaled product is used for
  typedef enum logic [2:0] {
    PH_JUDGE,
    PH_FTRIG,
    PH_RAISE,
    PH_LSUST,
    PH_LEARLY
  } phase_t;

endpackage

@@ hdl/adaptive_threshold_tracker_unit.sv @@
// Each word steps from idle through dispatch and any multiplier passes to delivery,
// NCH being ceil(VALUE_WIDTH / 32); delivery waits while an earlier result still
// waits on out_stall. A new word is taken only in the idle state, after the last
// result is loaded out; the count of threshold * factor products (none to three),
// each NCH passes of the shared 32x24 multiplier, sets the time per word.
// Reset (rst_n low, synchronous): mode ok, threshold and all configuration registers
// at their reset values, episode start 0, output channel empty.
module adaptive_threshold_tracker_unit
  import att_pkg::*;
#(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // input channel
  input  logic                                            in_valid,
  output logic                                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]                   in_sample_value,
  input  logic [TIME_W-1:0]                               in_sample_time,
  // result channel
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output logic signed [VALUE_WIDTH-1:0]                   out_threshold_out,
  output logic [1:0]                                      out_mode_after,
  // configuration
  input  logic                                            cfg_we,
  input  logic [CFG_IDX_W-1:0]                            cfg_index,
  input  logic [((VALUE_WIDTH > DELAY_W) ? VALUE_WIDTH : DELAY_W)-1:0] cfg_wdata
);

  localparam int VW    = VALUE_WIDTH;
  localparam int NCH   = (VW + CHUNK_W - 1) / CHUNK_W;
  localparam int MAG_W = NCH * CHUNK_W;
  localparam int ACC_W = MAG_W + FACTOR_W;
  localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [VW-1:0]    VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0]    VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [ACC_W-1:0] RND_ADD = (ACC_W'(1) << FRACTION_BITS) - ACC_W'(1);
  localparam logic [VW-1:0]    INIT_THR_RST = VW'(64'd6553600);

  // configuration registers
  logic [FACTOR_W-1:0]   trig_fac_r;
  logic [FACTOR_W-1:0]   raise_fac_r;
  logic [FACTOR_W-1:0]   lower_fac_r;
  logic signed [VW-1:0]  ceil_r;
  logic signed [VW-1:0]  floor_r;
  logic [DELAY_W-1:0]    rise_dly_r;
  logic [DELAY_W-1:0]    fall_dly_r;

  // tracker state and sequencer
  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  mode_t                 mode_r, mode_nxt;
  logic signed [VW-1:0]  thr_r, thr_nxt;
  logic [TIME_W-1:0]     start_r, start_nxt;
  logic signed [VW-1:0]  v_r, v_nxt;
  logic [TIME_W-1:0]     t_r, t_nxt;
  logic signed [VW-1:0]  res_r, res_nxt;

  // shared multiplier datapath
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [FACTOR_W-1:0]   fac_r, fac_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [VW-1:0]  sc_r, sc_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]  out_thr_r, out_thr_nxt;
  mode_t                 out_mode_r, out_mode_nxt;

  // shared compare and timing signals
  logic                  v_gt_thr;
  logic                  v_gt_trig;
  logic                  v_lt_trig;
  logic [DELAY_W-1:0]    dly;
  logic [TIME_W:0]       diff;
  logic                  pers;
  logic                  out_free;
  logic [VW-1:0]         thr_abs;
  logic [CHUNK_W+FACTOR_W-1:0] prod;
  logic [ACC_W-1:0]      rnd_sum;
  logic [ACC_W-1:0]      quo;
  logic                  sat;
  logic [VW-1:0]         q_lo;

  assign v_gt_thr  = v_r > thr_r;
  assign v_gt_trig = v_r > sc_r;
  assign v_lt_trig = v_r < sc_r;

  // episode persisted: time moved forward by more than the delay
  assign dly  = (mode_r == MODE_RISING) ? rise_dly_r : fall_dly_r;
  assign diff = {1'b0, t_r} - {1'b0, start_r};
  assign pers = !diff[TIME_W] && (diff[TIME_W-1:0] > TIME_W'(dly));

  assign out_free = !out_valid_r || !out_stall;

  // one chunk of the magnitude times the factor, top chunk first
  assign thr_abs = thr_r[VW-1] ? VW'(-thr_r) : VW'(thr_r);
  assign prod    = mag_r[MAG_W-1 -: CHUNK_W] * fac_r;

  // round toward minus infinity, then saturate
  assign rnd_sum = acc_r + (neg_r ? RND_ADD : '0);
  assign quo     = rnd_sum >> FRACTION_BITS;
  assign sat     = quo > ACC_W'(VAL_MAX);
  assign q_lo    = quo[VW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (mode_r == MODE_RISING && !(v_gt_thr && pers)) state_nxt = S_OUT;
        else state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == '0) state_nxt = S_RND;
      end
      S_RND: state_nxt = S_APPLY;
      S_APPLY: begin
        case (phase_r)
          PH_JUDGE:  state_nxt = S_OUT;
          PH_FTRIG: begin
            if (!v_gt_trig && pers) state_nxt = S_LOAD;
            else if (v_gt_thr)      state_nxt = S_OUT;
            else if (v_gt_trig)     state_nxt = S_LOAD;
            else                    state_nxt = S_OUT;
          end
          PH_RAISE:  state_nxt = S_LOAD;
          PH_LSUST:  state_nxt = S_LOAD;
          PH_LEARLY: state_nxt = S_OUT;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    thr_nxt       = thr_r;
    start_nxt     = start_r;
    v_nxt         = v_r;
    t_nxt         = t_r;
    res_nxt       = res_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    fac_nxt       = fac_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    sc_nxt        = sc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_thr_nxt   = out_thr_r;
    out_mode_nxt  = out_mode_r;

    case (state_r)
      S_IDLE: begin
        // capture the word
        if (in_valid) begin
          v_nxt = in_sample_value;
          t_nxt = in_sample_time;
        end
        // writing the initial threshold also loads the live threshold
        if (cfg_we && cfg_index == CFG_INITIAL_THRESHOLD) begin
          thr_nxt = cfg_wdata[VW-1:0];
        end
      end
      S_DISPATCH: begin
        case (mode_r)
          MODE_RISING: begin
            if (v_gt_thr && pers) begin
              phase_nxt = PH_RAISE;
            end else begin
              res_nxt  = thr_r;
              mode_nxt = v_gt_thr ? MODE_RISING : MODE_OK;
            end
          end
          MODE_FALLING: phase_nxt = PH_FTRIG;
          default:      phase_nxt = PH_JUDGE;
        endcase
      end
      S_LOAD: begin
        // start a product of the live threshold
        neg_nxt = thr_r[VW-1];
        mag_nxt = MAG_W'(thr_abs);
        acc_nxt = '0;
        cnt_nxt = CNT_W'(NCH - 1);
        case (phase_r)
          PH_RAISE:  fac_nxt = raise_fac_r;
          PH_LSUST:  fac_nxt = lower_fac_r;
          PH_LEARLY: fac_nxt = lower_fac_r;
          default:   fac_nxt = trig_fac_r;
        endcase
      end
      S_MUL: begin
        // accumulate one chunk, then advance to the next lower one
        acc_nxt = {acc_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
        mag_nxt = mag_r << CHUNK_W;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      S_RND: begin
        if (sat)        sc_nxt = neg_r ? VAL_MIN : VAL_MAX;
        else if (neg_r) sc_nxt = -q_lo;
        else            sc_nxt = q_lo;
      end
      S_APPLY: begin
        case (phase_r)
          PH_JUDGE: begin
            res_nxt = thr_r;
            if (v_gt_thr) begin
              mode_nxt  = MODE_RISING;
              start_nxt = t_r;
            end else if (v_lt_trig) begin
              mode_nxt  = MODE_FALLING;
              start_nxt = t_r;
            end else begin
              mode_nxt  = MODE_OK;
            end
          end
          PH_FTRIG: begin
            if (!v_gt_trig && pers) begin
              phase_nxt = PH_LSUST;
            end else begin
              res_nxt = thr_r;
              if (v_gt_thr) begin
                mode_nxt  = MODE_RISING;
                start_nxt = t_r;
              end else if (v_gt_trig) begin
                phase_nxt = PH_LEARLY;
              end
            end
          end
          PH_RAISE: begin
            thr_nxt   = (sc_r < ceil_r) ? sc_r : ceil_r;
            mode_nxt  = MODE_OK;
            phase_nxt = PH_JUDGE;
          end
          PH_LSUST: begin
            thr_nxt   = (sc_r > floor_r) ? sc_r : floor_r;
            mode_nxt  = MODE_OK;
            phase_nxt = PH_JUDGE;
          end
          PH_LEARLY: begin
            // early end of a fall: scaled, not floored
            thr_nxt  = sc_r;
            mode_nxt = MODE_OK;
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_thr_nxt   = res_r;
          out_mode_nxt  = mode_r;
        end
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_JUDGE;
      mode_r      <= MODE_OK;
      thr_r       <= INIT_THR_RST;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      thr_r       <= thr_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    t_r        <= t_nxt;
    res_r      <= res_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    fac_r      <= fac_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    sc_r       <= sc_nxt;
    out_thr_r  <= out_thr_nxt;
    out_mode_r <= out_mode_nxt;
  end

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_fac_r  <= LOWER_TRIGGER_RST;
      raise_fac_r <= RAISE_FACTOR_RST;
      lower_fac_r <= LOWER_FACTOR_RST;
      ceil_r      <= VAL_MAX;
      floor_r     <= '0;
      rise_dly_r  <= RISE_DELAY_RST;
      fall_dly_r  <= FALL_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        // the live threshold takes this one directly
        CFG_INITIAL_THRESHOLD:    ;
        CFG_LOWER_TRIGGER_FACTOR: trig_fac_r  <= cfg_wdata[FACTOR_W-1:0];
        CFG_RAISE_FACTOR:         raise_fac_r <= cfg_wdata[FACTOR_W-1:0];
        CFG_LOWER_FACTOR:         lower_fac_r <= cfg_wdata[FACTOR_W-1:0];
        CFG_THRESHOLD_CEILING:    ceil_r      <= cfg_wdata[VW-1:0];
        CFG_THRESHOLD_FLOOR:      floor_r     <= cfg_wdata[VW-1:0];
        CFG_RISE_DELAY:           rise_dly_r  <= cfg_wdata[DELAY_W-1:0];
        CFG_FALL_DELAY:           fall_dly_r  <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_threshold_out = out_thr_r;
  assign out_mode_after    = out_mode_r;

  // threshold moves only during a step or by a write of the initial threshold
  a_thr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !(cfg_we && cfg_index == CFG_INITIAL_THRESHOLD))
      |=> $stable(thr_r))
    else $error("threshold changed while idle");

  // a new word appears only from the delivery state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r) == S_OUT)
    else $error("result word loaded outside delivery");

  // the last multiplier pass hands over to rounding
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == '0) |=> state_r == S_RND)
    else $error("multiplier pass count broken");

  // entering an episode records the sample time
  a_ep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != $past(mode_r) && mode_r != MODE_OK && $past(rst_n)) |-> start_r == t_r)
    else $error("episode start not recorded");

endmodule
